FILE: hdl/sacache_pkg.sv
// ----------------------------------------------------------------------------
// sacache_pkg
// Shared types and constants of the set-associative cache hit/miss model.
// ----------------------------------------------------------------------------
package sacache_pkg;

  localparam int unsigned AddrWidth   = 64;
  localparam int unsigned ResultWidth = 32;
  localparam int unsigned CfgAddrW    = 4;
  localparam int unsigned CfgDataW    = 32;

  // Register indexes, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_POLICY   = 2'd0,
    REG_SET_LOG2 = 2'd1,
    REG_WAYS     = 2'd2,
    REG_NONE     = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    POLICY_LRU  = 1'b0,
    POLICY_FIFO = 1'b1
  } policy_e;

  typedef enum logic {
    MODE_READ  = 1'b0,
    MODE_WRITE = 1'b1
  } mode_e;

  typedef struct packed {
    logic [AddrWidth-1:0] access_address;
    logic                 mode;
  } in_item_t;

  typedef struct packed {
    logic                   hit;
    logic [ResultWidth-1:0] read_count;
    logic [ResultWidth-1:0] write_count;
    logic [ResultWidth-1:0] read_miss_count;
    logic [ResultWidth-1:0] write_miss_count;
  } out_item_t;

endpackage

FILE: hdl/set_assoc_cache_hit_miss_model_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_hit_miss_model_unit
// Tag store of a set-associative cache with LRU or FIFO replacement and
// saturating read, write, read-miss and write-miss counters.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+------------------------
//  in       | input     | in_valid_i / in_stall_o      | in_data_i  (in_item_t)
//  out      | output    | out_valid_o / out_stall_i    | out_data_o (out_item_t)
//  config   | input     | psel/penable/pwrite, pready  | paddr, pwdata, prdata
//
//  For an access, the set row is read from the tag-store memory into a
//  register in the transfer cycle, then compared, updated and written back
//  in the lookup state. The next access is taken once the row has been
//  written back. After reset a clearing pass initializes every row (valid
//  bits off, ranks equal to way numbers); no access is taken meanwhile.
//  A stalled result holds in the output register; the lookup waits for it.
// ----------------------------------------------------------------------------
module set_assoc_cache_hit_miss_model_unit #(
  parameter int unsigned SETS        = 64,
  parameter int unsigned WAYS        = 8,
  parameter int unsigned BLOCK_BYTES = 64,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  sacache_pkg::in_item_t               in_data_i,

  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output sacache_pkg::out_item_t              out_data_o,

  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sacache_pkg::CfgAddrW-1:0]    paddr,
  input  logic [sacache_pkg::CfgDataW-1:0]    pwdata,
  output logic [sacache_pkg::CfgDataW-1:0]    prdata,
  output logic                                pready
);

  localparam int unsigned OffBits = $clog2(BLOCK_BYTES);
  localparam int unsigned TagW    = sacache_pkg::AddrWidth - OffBits;
  localparam int unsigned SetBits = $clog2(SETS);
  localparam int unsigned SidxW   = (SetBits > 0) ? SetBits : 1;
  localparam int unsigned RankW   = ($clog2(WAYS) > 0) ? $clog2(WAYS) : 1;
  localparam int unsigned WcntW   = $clog2(WAYS + 1);

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_e;

  typedef struct packed {
    logic [WAYS-1:0][TagW-1:0]  tag;
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0][RankW-1:0] rank;
  } row_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic       policy_q;
  logic [2:0] set_log2_q;
  logic [3:0] ways_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q   <= sacache_pkg::POLICY_LRU;
      set_log2_q <= 3'd6;
      ways_q     <= 4'd8;
    end else if (cfg_wr) begin
      case (sacache_pkg::cfg_reg_e'(paddr[3:2]))
        sacache_pkg::REG_POLICY:   policy_q   <= pwdata[0];
        sacache_pkg::REG_SET_LOG2: set_log2_q <= pwdata[2:0];
        sacache_pkg::REG_WAYS:     ways_q     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sacache_pkg::cfg_reg_e'(paddr[3:2]))
      sacache_pkg::REG_POLICY:   prdata = {31'd0, policy_q};
      sacache_pkg::REG_SET_LOG2: prdata = {29'd0, set_log2_q};
      sacache_pkg::REG_WAYS:     prdata = {28'd0, ways_q};
      default:                   prdata = '0;
    endcase
  end

  // Effective set bits and associativity
  logic [2:0]       set_log2_eff;
  logic [WcntW-1:0] ways_eff;

  always_comb begin
    if (int'(set_log2_q) > int'(SetBits)) begin
      set_log2_eff = 3'(SetBits);
    end else begin
      set_log2_eff = set_log2_q;
    end
    if (ways_q == 4'd0) begin
      ways_eff = WcntW'(1);
    end else if (int'(ways_q) > int'(WAYS)) begin
      ways_eff = WcntW'(WAYS);
    end else begin
      ways_eff = WcntW'(ways_q);
    end
  end

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  state_e           state_q, state_d;
  logic [SidxW-1:0] clr_q, clr_d;
  logic             in_xfer;
  logic             done;
  logic             out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign done        = (state_q == ST_LOOKUP) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + SidxW'(1);
        if (clr_q == SidxW'(SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // --------------------------------------------------------------------------
  // Address split and access capture
  // --------------------------------------------------------------------------
  logic [TagW-1:0]  in_block;
  logic [SidxW-1:0] in_set;
  logic [SidxW-1:0] set_mask;
  logic [TagW-1:0]  in_tag;
  logic [SidxW-1:0] set_q;
  logic [TagW-1:0]  tag_q;
  logic             mode_q;

  assign in_block = in_data_i.access_address[sacache_pkg::AddrWidth-1:OffBits];
  assign set_mask = ~({SidxW{1'b1}} << set_log2_eff);
  assign in_set   = in_block[SidxW-1:0] & set_mask;
  assign in_tag   = in_block >> set_log2_eff;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      set_q  <= in_set;
      tag_q  <= in_tag;
      mode_q <= in_data_i.mode;
    end
  end

  // --------------------------------------------------------------------------
  // Tag-store memory: one row per set
  // --------------------------------------------------------------------------
  row_t             mem_q [SETS];
  row_t             rd_row_q;
  row_t             wr_row;
  row_t             clr_row;
  logic             mem_we;
  logic [SidxW-1:0] mem_waddr;

  always_comb begin
    clr_row = '0;
    for (int i = 0; i < WAYS; i++) begin
      clr_row.rank[i] = RankW'(i);
    end
  end

  assign mem_we    = (state_q == ST_CLEAR) || done;
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : set_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= (state_q == ST_CLEAR) ? clr_row : wr_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rd_row_q <= mem_q[in_set];
    end
  end

  // --------------------------------------------------------------------------
  // Compare, victim choice and rank update
  // --------------------------------------------------------------------------
  logic [WAYS-1:0]  in_use;
  logic [WAYS-1:0]  way_match;
  logic [WAYS-1:0]  way_oldest;
  logic             hit;
  logic [RankW-1:0] hit_way;
  logic             inv_found;
  logic [RankW-1:0] inv_way;
  logic [RankW-1:0] old_way;
  logic [RankW-1:0] sel_way;
  logic [RankW-1:0] sel_rank;
  logic             upd_rank;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      in_use[i]    = (i < int'(ways_eff));
      way_match[i] = in_use[i] && rd_row_q.valid[i] && (rd_row_q.tag[i] == tag_q);
    end
    // oldest way: strictly below every lower way, not above any higher way
    for (int i = 0; i < WAYS; i++) begin
      way_oldest[i] = in_use[i];
      for (int j = 0; j < WAYS; j++) begin
        if (in_use[j] && j < i && !(rd_row_q.rank[j] > rd_row_q.rank[i])) begin
          way_oldest[i] = 1'b0;
        end
        if (in_use[j] && j > i && (rd_row_q.rank[j] < rd_row_q.rank[i])) begin
          way_oldest[i] = 1'b0;
        end
      end
    end
  end

  // lowest-numbered way wins in each search
  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    old_way   = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (way_match[i]) begin
        hit     = 1'b1;
        hit_way = RankW'(i);
      end
      if (in_use[i] && !rd_row_q.valid[i]) begin
        inv_found = 1'b1;
        inv_way   = RankW'(i);
      end
      if (way_oldest[i]) begin
        old_way = RankW'(i);
      end
    end
  end

  assign sel_way  = hit ? hit_way : (inv_found ? inv_way : old_way);
  assign sel_rank = rd_row_q.rank[sel_way];
  assign upd_rank = !hit || (policy_q == sacache_pkg::POLICY_LRU);

  always_comb begin
    wr_row = rd_row_q;
    if (!hit) begin
      wr_row.tag[sel_way]   = tag_q;
      wr_row.valid[sel_way] = 1'b1;
    end
    if (upd_rank) begin
      for (int i = 0; i < WAYS; i++) begin
        if (in_use[i] && RankW'(i) != sel_way && rd_row_q.rank[i] > sel_rank) begin
          wr_row.rank[i] = rd_row_q.rank[i] - RankW'(1);
        end
      end
      wr_row.rank[sel_way] = RankW'(ways_eff - WcntW'(1));
    end
  end

  // --------------------------------------------------------------------------
  // Saturating counters and result register
  // --------------------------------------------------------------------------
  logic [COUNT_WIDTH-1:0] reads_q, reads_d;
  logic [COUNT_WIDTH-1:0] writes_q, writes_d;
  logic [COUNT_WIDTH-1:0] rmiss_q, rmiss_d;
  logic [COUNT_WIDTH-1:0] wmiss_q, wmiss_d;
  logic                   is_write;
  sacache_pkg::out_item_t out_q;

  assign is_write = (mode_q == sacache_pkg::MODE_WRITE);

  always_comb begin
    reads_d  = reads_q;
    writes_d = writes_q;
    rmiss_d  = rmiss_q;
    wmiss_d  = wmiss_q;
    if (is_write) begin
      if (!(&writes_q)) writes_d = writes_q + COUNT_WIDTH'(1);
      if (!hit && !(&wmiss_q)) wmiss_d = wmiss_q + COUNT_WIDTH'(1);
    end else begin
      if (!(&reads_q)) reads_d = reads_q + COUNT_WIDTH'(1);
      if (!hit && !(&rmiss_q)) rmiss_d = rmiss_q + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reads_q  <= '0;
      writes_q <= '0;
      rmiss_q  <= '0;
      wmiss_q  <= '0;
    end else if (done) begin
      reads_q  <= reads_d;
      writes_q <= writes_d;
      rmiss_q  <= rmiss_d;
      wmiss_q  <= wmiss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q.hit              <= hit;
      out_q.read_count       <= sacache_pkg::ResultWidth'(reads_d);
      out_q.write_count      <= sacache_pkg::ResultWidth'(writes_d);
      out_q.read_miss_count  <= sacache_pkg::ResultWidth'(rmiss_d);
      out_q.write_miss_count <= sacache_pkg::ResultWidth'(wmiss_d);
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: tb/cache_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cache_tb_pkg
// Scoreboard for the set-associative cache hit/miss unit: keeps its own copy of
// tags, valid bits, age ranks, counters and settings, predicts the result of
// each accepted access and checks every result leaving the unit in order.
// ----------------------------------------------------------------------------
package cache_tb_pkg;

  import sacache_pkg::*;

  localparam int TB_SETS      = 64;
  localparam int TB_WAYS      = 8;
  localparam int OFFSET_BITS  = 6;
  localparam int SET_BITS_MAX = 6;
  localparam int TAG_W        = AddrWidth - OFFSET_BITS;
  localparam int MAX_REPORTS  = 10;

  class cache_hit_scoreboard;
    logic [TAG_W-1:0] tag_mem    [TB_SETS*TB_WAYS];
    bit               line_valid [TB_SETS*TB_WAYS];
    int unsigned      line_rank  [TB_SETS*TB_WAYS];
    bit [31:0]        reads, writes, read_misses, write_misses;
    policy_e          policy;
    bit [2:0]         set_log2;
    bit [3:0]         ways_cfg;
    out_item_t        predicted_results[$];
    int               errors;
    int               compared;
    int               accesses;
    int               hits;

    function new();
      for (int i = 0; i < TB_SETS*TB_WAYS; i++) begin
        tag_mem[i]    = '0;
        line_valid[i] = 1'b0;
        line_rank[i]  = i % TB_WAYS;
      end
      reads        = '0;
      writes       = '0;
      read_misses  = '0;
      write_misses = '0;
      policy       = POLICY_LRU;
      set_log2     = 3'd6;
      ways_cfg     = 4'd8;
      errors       = 0;
      compared     = 0;
      accesses     = 0;
      hits         = 0;
    endfunction

    function int eff_set_log2();
      return (set_log2 > SET_BITS_MAX) ? SET_BITS_MAX : int'(set_log2);
    endfunction

    function int eff_ways();
      if (ways_cfg == 0) return 1;
      return (ways_cfg > TB_WAYS) ? TB_WAYS : int'(ways_cfg);
    endfunction

    function int pending();
      return predicted_results.size();
    endfunction

    function void set_register(cfg_reg_e idx, logic [CfgDataW-1:0] value);
      case (idx)
        REG_POLICY:   policy = policy_e'(value[0]);
        REG_SET_LOG2: set_log2 = value[2:0];
        REG_WAYS:     ways_cfg = value[3:0];
        default:      ;
      endcase
    endfunction

    function bit [31:0] bump(bit [31:0] count);
      return (count == '1) ? count : count + 1;
    endfunction

    // Make a way newest: shift down every younger way in use.
    function void promote(int base, int nways, int way);
      int unsigned r;
      r = line_rank[base + way];
      for (int i = 0; i < nways; i++) begin
        if (i != way && line_rank[base + i] > r) line_rank[base + i]--;
      end
      line_rank[base + way] = nways - 1;
    endfunction

    function void note_access(in_item_t item);
      logic [TAG_W-1:0] blk, tag;
      int               s, nways, base, way;
      bit               hit, found;
      out_item_t        res;
      blk   = item.access_address[AddrWidth-1:OFFSET_BITS];
      s     = eff_set_log2();
      nways = eff_ways();
      base  = int'(blk & ((TAG_W'(1) << s) - 1)) * TB_WAYS;
      tag   = blk >> s;
      hit   = 1'b0;
      found = 1'b0;
      way   = 0;
      accesses++;
      if (item.mode == MODE_WRITE) writes = bump(writes);
      else reads = bump(reads);
      for (int i = 0; i < nways; i++) begin
        if (!hit && line_valid[base + i] && tag_mem[base + i] == tag) begin
          hit = 1'b1;
          way = i;
        end
      end
      if (hit) begin
        hits++;
        if (policy == POLICY_LRU) promote(base, nways, way);
      end else begin
        // Fill the first free way in use, else the oldest one.
        for (int i = 0; i < nways; i++) begin
          if (!found && !line_valid[base + i]) begin
            found = 1'b1;
            way   = i;
          end
        end
        if (!found) begin
          way = 0;
          for (int i = 1; i < nways; i++) begin
            if (line_rank[base + i] < line_rank[base + way]) way = i;
          end
        end
        tag_mem[base + way]    = tag;
        line_valid[base + way] = 1'b1;
        promote(base, nways, way);
        if (item.mode == MODE_WRITE) write_misses = bump(write_misses);
        else read_misses = bump(read_misses);
      end
      res.hit              = hit;
      res.read_count       = reads;
      res.write_count      = writes;
      res.read_miss_count  = read_misses;
      res.write_miss_count = write_misses;
      predicted_results.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (predicted_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: hit=%0d reads=%0d writes=%0d", got.hit,
                   got.read_count, got.write_count);
        return;
      end
      want = predicted_results.pop_front();
      compared++;
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("mismatch on result %0d:", compared);
          if (got.hit !== want.hit)
            $display("  hit: expected %0d, got %0d", want.hit, got.hit);
          if (got.read_count !== want.read_count)
            $display("  read_count: expected %0d, got %0d", want.read_count,
                     got.read_count);
          if (got.write_count !== want.write_count)
            $display("  write_count: expected %0d, got %0d", want.write_count,
                     got.write_count);
          if (got.read_miss_count !== want.read_miss_count)
            $display("  read_miss_count: expected %0d, got %0d",
                     want.read_miss_count, got.read_miss_count);
          if (got.write_miss_count !== want.write_miss_count)
            $display("  write_miss_count: expected %0d, got %0d",
                     want.write_miss_count, got.write_miss_count);
        end
      end
    endfunction
  endclass

endpackage

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives accesses and register writes into the set-associative cache unit,
// with random idle and stall cycles on both channels, and checks every result
// against the scoreboard over LRU and FIFO settings and a range of set/way sizes.
// ----------------------------------------------------------------------------
module tb;

  import sacache_pkg::*;
  import cache_tb_pkg::*;

  localparam int PHASES          = 10;
  localparam int FIXED_PHASES    = 7;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int LONG_HOLD       = 200;
  localparam int DRAIN_CYCLES    = 10;
  localparam int TIMEOUT_NS      = 2_000_000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  in_item_t            in_data_i   = '0;
  logic                out_stall_i = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [CfgAddrW-1:0] paddr       = '0;
  logic [CfgDataW-1:0] pwdata      = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  out_item_t           out_data_o;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  cache_hit_scoreboard board = new();
  int                  in_gap_max  = 6;
  int                  out_gap_max = 6;
  int                  long_hold   = 0;
  logic [TAG_W-1:0]    tag_base    = '0;

  policy_e phase_policy [FIXED_PHASES] = '{POLICY_FIFO, POLICY_LRU, POLICY_FIFO,
                                          POLICY_LRU, POLICY_LRU, POLICY_FIFO,
                                          POLICY_LRU};
  int      phase_log2   [FIXED_PHASES] = '{0, 0, 7, 3, 1, 6, 2};
  int      phase_ways   [FIXED_PHASES] = '{1, 8, 15, 0, 2, 8, 4};

  set_assoc_cache_hit_miss_model_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic in_item_t access(logic [AddrWidth-1:0] addr, mode_e m);
    in_item_t item;
    item.access_address = addr;
    item.mode           = m;
    return item;
  endfunction

  // Mostly a small pool of tags on a few sets so that hits and evictions occur.
  function automatic in_item_t random_access();
    in_item_t               item;
    logic [TAG_W-1:0]       blk, set_mask;
    logic [OFFSET_BITS-1:0] offs;
    int                     s;
    s        = board.eff_set_log2();
    set_mask = (TAG_W'(1) << s) - 1;
    offs     = OFFSET_BITS'($urandom);
    if ($urandom_range(0, 99) < 15) begin
      item.access_address = {$urandom, $urandom};
    end else begin
      blk = (tag_base + $urandom_range(0, board.eff_ways() + 2)) << s;
      if ($urandom_range(0, 3) == 0) blk |= $urandom & set_mask;
      else blk |= $urandom_range(0, 3) & set_mask;
      item.access_address = {blk, offs};
    end
    item.mode = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
    return item;
  endfunction

  // Called at a rising edge; returns at the edge where the transfer happens.
  task automatic send_access(in_item_t item);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    board.note_access(item);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    board.set_register(idx, value);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Result side: random stall before each transfer, one long hold on request.
  initial begin
    int gap;
    wait (rst_ni === 1'b1);
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (long_hold > 0) begin
        gap       = long_hold;
        long_hold = 0;
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      board.check_result(out_data_o);
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_access(access(64'h0, MODE_READ));
    send_access(access(64'h0, MODE_WRITE));
    send_access(access(64'h3F, MODE_READ));
    send_access(access('1, MODE_READ));
    send_access(access('1, MODE_WRITE));
    // Overfill set 0 so the oldest entries get evicted.
    for (int t = 1; t <= 9; t++)
      send_access(access(64'(t) << 12, (t % 2) ? MODE_WRITE : MODE_READ));
    send_access(access(64'h1000, MODE_READ));
    send_access(access(64'h5000, MODE_WRITE));
    send_access(access(64'h40, MODE_READ));

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      if (p < FIXED_PHASES) begin
        write_reg(REG_POLICY, CfgDataW'(phase_policy[p]));
        write_reg(REG_SET_LOG2, CfgDataW'(phase_log2[p]));
        write_reg(REG_WAYS, CfgDataW'(phase_ways[p]));
      end else begin
        write_reg(REG_POLICY, $urandom);
        write_reg(REG_SET_LOG2, $urandom);
        write_reg(REG_WAYS, $urandom);
      end
      if (p == 2) write_reg(REG_NONE, $urandom);
      tag_base    = (p % 3 == 0) ? '0 : TAG_W'({$urandom, $urandom});
      in_gap_max  = (p % 4 == 2) ? 0 : 6;
      out_gap_max = (p % 4 == 2) ? 0 : 6;
      if (p == 1) begin
        // Keep offering while the result side holds off.
        in_gap_max = 0;
        long_hold  = LONG_HOLD;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 4 && n == ITEMS_PER_PHASE / 2) drain_results();
        send_access(random_access());
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d accesses (%0d hits) across %0d register settings, LRU and FIFO,",
             board.accesses, board.hits, PHASES + 1);
    $display("with idle/stall gaps and one long output hold; %0d results compared.",
             board.compared);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

endmodule
